FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the packed Morse decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define PMSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Condition checked on the edge after reset is seen low.
`define PMSD_ASSERT_AFTER_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("assertion failed");
`else
`define PMSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PMSD_ASSERT_AFTER_RST(lbl, clk, rstn, cons)
`endif

`endif

FILE: design/pmsd_pkg.sv
// ----------------------------------------------------------------------------
// Packed Morse decoder package
// Symbol codes, the Morse code table and the table lookup function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmsd_pkg;

    // Widths fixed by the item fields.
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int NUM_SYMS    = 4;
    localparam int SYM_W       = 2;

    // Widths of the code table entries.
    localparam int CODE_BITS_W = 8;
    localparam int CODE_LEN_W  = 4;
    localparam int NUM_CODES   = 46;

    localparam int DEFAULT_MAX_CODE_LEN = 7;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;
    localparam logic [CHAR_W-1:0] NO_CHAR    = 7'd0;

    // Two-bit symbol codes carried in the packed byte.
    typedef enum logic [SYM_W-1:0] {
        SYM_LETTER_END = 2'd0,
        SYM_DASH       = 2'd1,
        SYM_DOT        = 2'd2,
        SYM_WORD_END   = 2'd3
    } t_sym;

    // One classified byte passed from the front to the back.
    typedef struct packed {
        logic                  valid;
        t_sym [NUM_SYMS-1:0]   syms;
    } t_sym_item;

    // One Morse code: dash is 1 and dot is 0, first mark most significant.
    typedef struct packed {
        logic [CODE_LEN_W-1:0]  len;
        logic [CODE_BITS_W-1:0] bits;
        logic [CHAR_W-1:0]      chr;
    } t_code_entry;

    localparam t_code_entry CODE_TABLE [NUM_CODES] = '{
        '{4'd2, 8'b01,      7'd65},  // A
        '{4'd4, 8'b1000,    7'd66},  // B
        '{4'd4, 8'b1010,    7'd67},  // C
        '{4'd3, 8'b100,     7'd68},  // D
        '{4'd1, 8'b0,       7'd69},  // E
        '{4'd4, 8'b0010,    7'd70},  // F
        '{4'd3, 8'b110,     7'd71},  // G
        '{4'd4, 8'b0000,    7'd72},  // H
        '{4'd2, 8'b00,      7'd73},  // I
        '{4'd4, 8'b0111,    7'd74},  // J
        '{4'd3, 8'b101,     7'd75},  // K
        '{4'd4, 8'b0100,    7'd76},  // L
        '{4'd2, 8'b11,      7'd77},  // M
        '{4'd2, 8'b10,      7'd78},  // N
        '{4'd3, 8'b111,     7'd79},  // O
        '{4'd4, 8'b0110,    7'd80},  // P
        '{4'd4, 8'b1101,    7'd81},  // Q
        '{4'd3, 8'b010,     7'd82},  // R
        '{4'd3, 8'b000,     7'd83},  // S
        '{4'd1, 8'b1,       7'd84},  // T
        '{4'd3, 8'b001,     7'd85},  // U
        '{4'd4, 8'b0001,    7'd86},  // V
        '{4'd3, 8'b011,     7'd87},  // W
        '{4'd4, 8'b1001,    7'd88},  // X
        '{4'd4, 8'b1011,    7'd89},  // Y
        '{4'd4, 8'b1100,    7'd90},  // Z
        '{4'd5, 8'b11111,   7'd48},  // 0
        '{4'd5, 8'b01111,   7'd49},  // 1
        '{4'd5, 8'b00111,   7'd50},  // 2
        '{4'd5, 8'b00011,   7'd51},  // 3
        '{4'd5, 8'b00001,   7'd52},  // 4
        '{4'd5, 8'b00000,   7'd53},  // 5
        '{4'd5, 8'b10000,   7'd54},  // 6
        '{4'd5, 8'b11000,   7'd55},  // 7
        '{4'd5, 8'b11100,   7'd56},  // 8
        '{4'd5, 8'b11110,   7'd57},  // 9
        '{4'd6, 8'b011110,  7'd39},  // apostrophe
        '{4'd6, 8'b011010,  7'd64},  // at sign
        '{4'd6, 8'b111000,  7'd58},  // colon
        '{4'd6, 8'b110011,  7'd44},  // comma
        '{4'd7, 8'b0001001, 7'd36},  // dollar
        '{4'd5, 8'b10001,   7'd61},  // equals
        '{4'd6, 8'b101011,  7'd33},  // exclamation mark
        '{4'd6, 8'b010101,  7'd46},  // full stop
        '{4'd6, 8'b001100,  7'd63},  // question mark
        '{4'd6, 8'b010010,  7'd34}   // double quote
    };

    // Returns the character for a pattern, or NO_CHAR when nothing matches.
    function automatic logic [CHAR_W-1:0] code_lookup(
        input logic [CODE_BITS_W-1:0] bits,
        input logic [CODE_LEN_W-1:0]  len
    );
        logic [CHAR_W-1:0] chr;
        chr = NO_CHAR;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (CODE_TABLE[i].len == len && CODE_TABLE[i].bits == bits) begin
                chr = CODE_TABLE[i].chr;
            end
        end
        return chr;
    endfunction

endpackage

FILE: design/pmsd_stream_if.sv
// ----------------------------------------------------------------------------
// Packed Morse decoder channels
// Valid/ready channels for input bytes and decoded characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Input channel: one packed byte of four symbols per item.
interface pmsd_in_if;
    logic                         valid;
    logic                         ready;
    logic [pmsd_pkg::BYTE_W-1:0]  packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);
endinterface

// Output channel: one decoded character per item.
interface pmsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [pmsd_pkg::CHAR_W-1:0]  char_code;
    logic                         last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: design/pmsd_front.sv
// ----------------------------------------------------------------------------
// Packed Morse decoder front end
// Accepts bytes, splits them into symbol codes and queues them for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pmsd_in_if.sink              i_in,
    output pmsd_pkg::t_sym_item  o_item,
    input  logic                 i_pop
);
    import pmsd_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    t_sym [NUM_SYMS-1:0] r_q [QUEUE_DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    t_sym [NUM_SYMS-1:0] w_syms;
    logic                w_push;
    logic                w_pop;

    // Split the byte into symbols; symbol 3 holds the pair sent first.
    always_comb begin
        for (int k = 0; k < NUM_SYMS; k++) begin
            w_syms[k] = t_sym'(i_in.packed_byte[k*SYM_W +: SYM_W]);
        end
    end

    assign i_in.ready = (r_count != 2'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != 2'd0);

    assign o_item.valid = (r_count != 2'd0);
    assign o_item.syms  = r_q[r_rd_ptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_syms;
        end
    end

endmodule

FILE: design/pmsd_back.sv
// ----------------------------------------------------------------------------
// Packed Morse decoder back end
// Steps through one symbol a cycle unless stalled, matches letters and drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmsd_back #(
    parameter int MAX_CODE_LEN = pmsd_pkg::DEFAULT_MAX_CODE_LEN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmsd_pkg::t_sym_item  i_item,
    output logic                 o_pop,
    pmsd_out_if.source           o_out
);
    import pmsd_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 2);

    // Symbol sequencer.
    logic                      r_busy;
    t_sym [NUM_SYMS-1:0]       r_syms;
    logic [1:0]                r_idx;
    logic                      r_space_pend;

    // Pattern collected so far.
    logic [MAX_CODE_LEN-1:0]   r_bits;
    logic [LEN_W-1:0]          r_len;

    // Holding slot: keeps the newest result until it is known whether it is last.
    logic                      r_hold_valid;
    logic [CHAR_W-1:0]         r_hold_char;
    logic                      r_hold_last;

    // Output register.
    logic                      r_out_valid;
    logic [CHAR_W-1:0]         r_out_char;
    logic                      r_out_last;

    logic [MAX_CODE_LEN-1:0]   n_bits;
    logic [LEN_W-1:0]          n_len;
    logic                      n_space_pend;

    t_sym                      w_sym;
    logic                      w_len_ok;
    logic [CHAR_W-1:0]         w_match;
    logic                      w_emit;
    logic [CHAR_W-1:0]         w_emit_char;
    logic                      w_advance;
    logic                      w_out_free;
    logic                      w_step;
    logic                      w_final;
    logic                      w_load;
    logic                      w_hold_move;

    assign w_sym    = r_syms[r_idx];
    assign w_len_ok = (r_len != '0) && (r_len <= LEN_W'(MAX_CODE_LEN));
    assign w_match  = w_len_ok ?
                      code_lookup(CODE_BITS_W'(r_bits), CODE_LEN_W'(r_len)) : NO_CHAR;

    // Work done by the current symbol.
    always_comb begin
        w_emit       = 1'b0;
        w_emit_char  = w_match;
        w_advance    = 1'b1;
        n_bits       = r_bits;
        n_len        = r_len;
        n_space_pend = 1'b0;
        if (r_space_pend) begin
            w_emit      = 1'b1;
            w_emit_char = SPACE_CHAR;
        end else begin
            unique case (w_sym)
                SYM_DASH, SYM_DOT: begin
                    if (r_len < LEN_W'(MAX_CODE_LEN)) begin
                        n_bits = {r_bits[MAX_CODE_LEN-2:0], (w_sym == SYM_DASH)};
                        n_len  = r_len + LEN_W'(1);
                    end else begin
                        n_len  = LEN_W'(MAX_CODE_LEN + 1);
                    end
                end
                SYM_LETTER_END: begin
                    n_bits = '0;
                    n_len  = '0;
                    w_emit = (w_match != NO_CHAR);
                end
                SYM_WORD_END: begin
                    n_bits = '0;
                    n_len  = '0;
                    w_emit = 1'b1;
                    if (w_match != NO_CHAR) begin
                        // Letter first, the space follows on the next step.
                        n_space_pend = 1'b1;
                        w_advance    = 1'b0;
                    end else begin
                        w_emit_char  = SPACE_CHAR;
                    end
                end
            endcase
        end
    end

    // A result can only be produced if the holding slot can be emptied.
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_step      = r_busy && (!w_emit || !r_hold_valid || w_out_free);
    assign w_final     = w_step && w_advance && (r_idx == 2'd0);
    assign w_load      = i_item.valid && (!r_busy || w_final);
    assign w_hold_move = r_hold_valid && w_out_free && (r_hold_last || (w_step && w_emit));
    assign o_pop       = w_load;

    // Control and pattern state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_space_pend <= 1'b0;
            r_bits       <= '0;
            r_len        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_final) begin
                r_busy <= 1'b0;
            end
            if (w_step) begin
                r_space_pend <= n_space_pend;
                r_bits       <= n_bits;
                r_len        <= n_len;
            end
            if (w_step && w_emit) begin
                r_hold_valid <= 1'b1;
            end else if (w_hold_move) begin
                r_hold_valid <= 1'b0;
            end
            if (w_hold_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers; the symbol slot starts defined so the decoder never sees unknowns.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMS; k++) begin
                r_syms[k] <= SYM_LETTER_END;
            end
            r_idx <= '0;
        end else if (w_load) begin
            r_syms <= i_item.syms;
            r_idx  <= 2'(NUM_SYMS - 1);
        end else if (w_step && w_advance) begin
            r_idx  <= r_idx - 2'd1;
        end
        if (w_step && w_emit) begin
            r_hold_char <= w_emit_char;
            r_hold_last <= w_final;
        end else if (w_final && r_hold_valid) begin
            // The held result is the last one of its byte.
            r_hold_last <= 1'b1;
        end
        if (w_hold_move) begin
            r_out_char <= r_hold_char;
            r_out_last <= r_hold_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_out_char;
    assign o_out.last      = r_out_last;

endmodule

FILE: design/packed_morse_symbol_decoder_core.sv
// ----------------------------------------------------------------------------
// Packed Morse symbol decoder core
// Throughput: the back-end symbol sequencer handles one symbol a cycle
// while the result path does not stall, with an extra step for each word
// end that closes a matched letter; the next byte is loaded on the final
// step of the current one. The newest result is held until the next one or
// the end of its byte, then moves to the output register.
// Reset: synchronous, active low; clears the queue, pattern and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_morse_symbol_decoder_core #(
    parameter int MAX_CODE_LEN = pmsd_pkg::DEFAULT_MAX_CODE_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmsd_in_if.sink     i_in,
    pmsd_out_if.source  o_out
);
    import pmsd_pkg::*;

    t_sym_item w_item;
    logic      w_pop;

    // Front end: byte queue and symbol split.
    pmsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    // Back end: symbol sequencer, code match and result output.
    pmsd_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // The back end only takes a byte that the queue holds.
    `PMSD_ASSERT_IMP(a_pop_needs_item, i_clk, i_rst_n, w_pop, w_item.valid)
    // Every character leaving the block is printable.
    `PMSD_ASSERT_IMP(a_char_range, i_clk, i_rst_n, o_out.valid, o_out.char_code >= SPACE_CHAR)
    // No result is offered right after reset.
    `PMSD_ASSERT_AFTER_RST(a_rst_out_idle, i_clk, i_rst_n, !o_out.valid)
    // The queue never offers a byte right after reset.
    `PMSD_ASSERT_AFTER_RST(a_rst_queue_empty, i_clk, i_rst_n, !w_item.valid)

endmodule
